// File: rtl/dur_pkg.sv
`timescale 1ns / 1ps
package dur_pkg;

  // Window depths of the two stages
  localparam logic [2:0] FRONT_DEPTH = 3'd4;
  localparam logic [2:0] BACK_DEPTH  = 3'd5;

  // UTF-8 structure masks and tags
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Repaired code byte base, and the two Latin-1 lead bytes matched by range
  localparam logic [7:0] CODE_BASE = 8'h80;
  localparam logic [7:0] LATIN_C2  = 8'hC2;
  localparam logic [7:0] LATIN_C3  = 8'hC3;
  localparam logic [7:0] C2_LO     = 8'hA0;
  localparam logic [7:0] C3_LO     = 8'h80;
  localparam logic [7:0] LATIN_HI  = 8'hBF;
  localparam logic [7:0] C3_OFFSET = 8'h40;
  localparam logic [7:0] NO_THIRD  = 8'h00;

  localparam int RomRows = 32;

  // Code points 0x80..0x9F of the single-byte code page; a zero third byte
  // marks a two-byte entry.
  localparam logic [23:0] ROM_LOW [RomRows] = '{
    24'hE282AC, 24'hC28100, 24'hE2809A, 24'hC69200,
    24'hE2809E, 24'hE280A6, 24'hE280A0, 24'hE280A1,
    24'hCB8600, 24'hE280B0, 24'hC5A000, 24'hE280B9,
    24'hC59200, 24'hC28D00, 24'hC5BD00, 24'hC28F00,
    24'hC29000, 24'hE28098, 24'hE28099, 24'hE2809C,
    24'hE2809D, 24'hE280A2, 24'hE28093, 24'hE28094,
    24'hCB9C00, 24'hE284A2, 24'hC5A100, 24'hE280BA,
    24'hC59300, 24'hC29D00, 24'hC5BE00, 24'hC5B800
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } dur_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } dur_out_t;

  // Bytes forwarded by one front decision
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n;
    logic            item_end;
    logic            eos;
  } chunk_t;

  // Bytes emitted by one back decision; mark closes the word's results
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n;
    logic            mark;
  } group_t;

  typedef struct packed {
    logic [2:0]      used;
    logic [3:0][7:0] data;
    logic [2:0]      n;
  } fdec_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } rom_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic logic [2:0] seq_len(input logic [3:0][7:0] v);
    logic [2:0] len;
    len = 3'd0;
    if (!v[0][7]) begin
      len = 3'd1;
    end else if ((v[0] & LEAD2_MASK) == LEAD2_TAG && is_cont(v[1])) begin
      len = 3'd2;
    end else if ((v[0] & LEAD3_MASK) == LEAD3_TAG && is_cont(v[1]) && is_cont(v[2])) begin
      len = 3'd3;
    end else if ((v[0] & LEAD4_MASK) == LEAD4_TAG && is_cont(v[1]) && is_cont(v[2]) &&
                 is_cont(v[3])) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Read zero past the held count
  function automatic logic [3:0][7:0] view4(input logic [3:0][7:0] w, input logic [2:0] cnt);
    logic [3:0][7:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cnt) v[k] = w[k];
    end
    return v;
  endfunction

  function automatic rom_t rom_find(input logic [3:0][7:0] v);
    rom_t r;
    r.hit  = 1'b0;
    r.code = '0;
    for (int k = RomRows - 1; k >= 0; k--) begin
      if (v[0] == ROM_LOW[k][23:16] && v[1] == ROM_LOW[k][15:8] &&
          (ROM_LOW[k][7:0] == NO_THIRD || v[2] == ROM_LOW[k][7:0])) begin
        r.hit  = 1'b1;
        r.code = CODE_BASE + 8'(k);
      end
    end
    if (!r.hit && v[0] == LATIN_C2 && v[1] >= C2_LO && v[1] <= LATIN_HI) begin
      r.hit  = 1'b1;
      r.code = v[1];
    end else if (!r.hit && v[0] == LATIN_C3 && v[1] >= C3_LO && v[1] <= LATIN_HI) begin
      r.hit  = 1'b1;
      r.code = v[1] + C3_OFFSET;
    end
    return r;
  endfunction

  function automatic fdec_t front_dec(input logic [3:0][7:0] v);
    fdec_t d;
    logic [2:0] len;
    rom_t r;
    len = seq_len(v);
    r = rom_find(v);
    d.data = v;
    d.used = len;
    d.n    = len;
    if (len == 3'd0) begin
      d.used = 3'd1;
      d.n    = 3'd0;
    end else if (len != 3'd1 && r.hit) begin
      d.n       = 3'd1;
      d.data    = '0;
      d.data[0] = r.code;
    end
    return d;
  endfunction

endpackage

// File: rtl/dur_front.sv
`timescale 1ns / 1ps
module dur_front
  import dur_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dur_in_t in_data,
  output logic    chunk_vld,
  output chunk_t  chunk,
  input  logic    chunk_done
);

  logic [3:0][7:0] win_r, win_nxt, win_app, win_src, win_shift;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      cnt_app, cnt_src, used, cnt_left;
  logic            flush_r, flush_nxt;
  logic            chunk_vld_r, chunk_vld_nxt;
  chunk_t          chunk_r, chunk_nxt;
  logic            slot_free, accept, drained;
  fdec_t           dec;

  function automatic logic [3:0][7:0] shift4(input logic [3:0][7:0] w, input logic [2:0] j);
    logic [3:0][7:0] s;
    logic [3:0]      idx;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      idx = 4'(k) + {1'b0, j};
      if (idx < 4'd4) s[k] = w[idx[1:0]];
    end
    return s;
  endfunction

  always_comb begin
    slot_free = !chunk_vld_r || chunk_done;
    in_ready  = slot_free && !flush_r;
    accept    = in_valid && in_ready;

    win_app        = win_r;
    win_app[cnt_r] = in_data.in_byte;
    cnt_app        = {1'b0, cnt_r} + 3'd1;
    win_src        = flush_r ? win_r : win_app;
    cnt_src        = flush_r ? {1'b0, cnt_r} : cnt_app;

    dec       = front_dec(view4(win_src, cnt_src));
    used      = (dec.used > cnt_src) ? cnt_src : dec.used;
    cnt_left  = cnt_src - used;
    win_shift = shift4(win_src, used);
    drained   = (cnt_left == 3'd0);

    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    flush_nxt     = flush_r;
    chunk_nxt     = chunk_r;
    chunk_vld_nxt = chunk_vld_r && !chunk_done;

    if (flush_r) begin
      // drain the window one decision per free slot
      if (slot_free) begin
        win_nxt            = win_shift;
        cnt_nxt            = cnt_left[1:0];
        chunk_nxt.data     = dec.data;
        chunk_nxt.n        = dec.n;
        chunk_nxt.item_end = drained;
        chunk_nxt.eos      = drained;
        chunk_vld_nxt      = 1'b1;
        flush_nxt          = !drained;
      end
    end else if (accept) begin
      chunk_nxt.data = dec.data;
      chunk_vld_nxt  = 1'b1;
      if (in_data.end_of_stream || cnt_app == FRONT_DEPTH) begin
        win_nxt     = win_shift;
        cnt_nxt     = cnt_left[1:0];
        chunk_nxt.n = dec.n;
      end else begin
        win_nxt     = win_app;
        cnt_nxt     = cnt_app[1:0];
        chunk_nxt.n = 3'd0;
      end
      if (in_data.end_of_stream) begin
        chunk_nxt.item_end = drained;
        chunk_nxt.eos      = drained;
        flush_nxt          = !drained;
      end else begin
        chunk_nxt.item_end = 1'b1;
        chunk_nxt.eos      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flush_r     <= 1'b0;
      chunk_vld_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      flush_r     <= flush_nxt;
      chunk_vld_r <= chunk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    chunk_r <= chunk_nxt;
  end

  assign chunk_vld = chunk_vld_r;
  assign chunk     = chunk_r;

`ifndef SYNTHESIS
  a_front_flush_holds_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> cnt_r != 2'd0)
    else $error("front flush with an empty window");
`endif

endmodule

// File: rtl/dur_back.sv
`timescale 1ns / 1ps
module dur_back
  import dur_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   chunk_vld,
  input  chunk_t chunk,
  output logic   chunk_done,
  output logic   grp_vld,
  output group_t grp,
  input  logic   grp_done
);

  logic [4:0][7:0] win_r, win_nxt, win_app, win_src, win_shift;
  logic [3:0][7:0] seq_v;
  logic [2:0]      cnt_r, cnt_nxt, cnt_app, cnt_src, cnt_left, cnt_post;
  logic [2:0]      len, used, grp_n;
  logic [1:0]      ptr_r, ptr_nxt;
  logic            flush_r, flush_nxt;
  logic            grp_vld_r, grp_vld_nxt;
  group_t          grp_r, grp_nxt;
  logic            slot_free, have_push, last_push, full, mark, grp_wr;

  function automatic logic [4:0][7:0] shift5(input logic [4:0][7:0] w, input logic [2:0] j);
    logic [4:0][7:0] s;
    logic [3:0]      idx;
    s = '0;
    for (int k = 0; k < 5; k++) begin
      idx = 4'(k) + {1'b0, j};
      if (idx < 4'd5) s[k] = w[idx[2:0]];
    end
    return s;
  endfunction

  always_comb begin
    slot_free = !grp_vld_r || grp_done;

    win_app        = win_r;
    win_app[cnt_r] = chunk.data[ptr_r];
    cnt_app        = cnt_r + 3'd1;
    win_src        = flush_r ? win_r : win_app;
    cnt_src        = flush_r ? cnt_r : cnt_app;

    seq_v     = view4(win_src[3:0], cnt_src);
    len       = seq_len(seq_v);
    used      = (len == 3'd0) ? 3'd1 : len;
    used      = (used > cnt_src) ? cnt_src : used;
    cnt_left  = cnt_src - used;
    win_shift = shift5(win_src, used);

    have_push = chunk_vld && !flush_r && ({1'b0, ptr_r} < chunk.n);
    last_push = ({1'b0, ptr_r} == chunk.n - 3'd1);
    full      = (cnt_app == BACK_DEPTH);
    cnt_post  = full ? cnt_left : cnt_app;

    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    flush_nxt  = flush_r;
    grp_n      = 3'd0;
    mark       = 1'b0;
    chunk_done = 1'b0;

    if (slot_free) begin
      if (flush_r) begin
        // one decision per free group slot until the window is empty
        win_nxt = win_shift;
        cnt_nxt = cnt_left;
        grp_n   = len;
        if (cnt_left == 3'd0) begin
          mark       = 1'b1;
          flush_nxt  = 1'b0;
          chunk_done = 1'b1;
        end
      end else if (have_push) begin
        if (full) begin
          win_nxt = win_shift;
          cnt_nxt = cnt_left;
          grp_n   = len;
        end else begin
          win_nxt = win_app;
          cnt_nxt = cnt_app;
        end
        if (last_push) begin
          ptr_nxt = '0;
          if (chunk.eos) begin
            if (cnt_post != 3'd0) begin
              flush_nxt = 1'b1;
            end else begin
              mark       = 1'b1;
              chunk_done = 1'b1;
            end
          end else begin
            mark       = chunk.item_end;
            chunk_done = 1'b1;
          end
        end else begin
          ptr_nxt = ptr_r + 2'd1;
        end
      end else if (chunk_vld && !flush_r) begin
        // chunk without bytes: pass the word boundary or start the flush
        if (chunk.eos && cnt_r != 3'd0) begin
          flush_nxt = 1'b1;
        end else begin
          mark       = chunk.eos || chunk.item_end;
          chunk_done = 1'b1;
        end
      end
    end

    grp_wr       = (grp_n != 3'd0) || mark;
    grp_nxt      = grp_r;
    if (grp_wr) begin
      grp_nxt.data = seq_v;
      grp_nxt.n    = grp_n;
      grp_nxt.mark = mark;
    end
    grp_vld_nxt = grp_wr || (grp_vld_r && !grp_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ptr_r     <= '0;
      flush_r   <= 1'b0;
      grp_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      ptr_r     <= ptr_nxt;
      flush_r   <= flush_nxt;
      grp_vld_r <= grp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    grp_r <= grp_nxt;
  end

  assign grp_vld = grp_vld_r;
  assign grp     = grp_r;

`ifndef SYNTHESIS
  a_back_flush_holds_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> cnt_r != 3'd0)
    else $error("back flush with an empty window");
  a_back_count_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < BACK_DEPTH)
    else $error("back window count left at depth");
`endif

endmodule

// File: rtl/dur_ser.sv
`timescale 1ns / 1ps
module dur_ser
  import dur_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     grp_vld,
  input  group_t   grp,
  output logic     grp_done,
  output logic     out_valid,
  input  logic     out_ready,
  output dur_out_t out_data
);

  logic [1:0] gptr_r, gptr_nxt;
  logic       hold_vld_r, hold_vld_nxt;
  logic       hold_fin_r, hold_fin_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       o_vld_r, o_vld_nxt;
  dur_out_t   o_r, o_nxt;
  logic       out_free, has_byte, last_b, take, move, marker;

  always_comb begin
    out_free = !o_vld_r || out_ready;
    has_byte = grp_vld && ({1'b0, gptr_r} < grp.n);
    last_b   = ({1'b0, gptr_r} == grp.n - 3'd1);
    marker   = grp_vld && (grp.n == 3'd0);
    take     = has_byte && (!hold_vld_r || out_free);
    // a held byte leaves once its last flag is known
    move     = hold_vld_r && (take || (hold_fin_r && out_free));
    grp_done = (take && last_b) || marker;

    gptr_nxt      = gptr_r;
    hold_vld_nxt  = hold_vld_r;
    hold_fin_nxt  = hold_fin_r;
    hold_byte_nxt = hold_byte_r;
    o_vld_nxt     = o_vld_r && !out_ready;
    o_nxt         = o_r;

    if (move) begin
      o_vld_nxt         = 1'b1;
      o_nxt.out_byte    = hold_byte_r;
      o_nxt.last_of_run = hold_fin_r;
      hold_vld_nxt      = 1'b0;
    end
    if (take) begin
      hold_vld_nxt  = 1'b1;
      hold_byte_nxt = grp.data[gptr_r];
      hold_fin_nxt  = grp.mark && last_b;
      gptr_nxt      = last_b ? 2'd0 : gptr_r + 2'd1;
    end else if (marker) begin
      hold_fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gptr_r     <= '0;
      hold_vld_r <= 1'b0;
      o_vld_r    <= 1'b0;
    end else begin
      gptr_r     <= gptr_nxt;
      hold_vld_r <= hold_vld_nxt;
      o_vld_r    <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_fin_r  <= hold_fin_nxt;
    hold_byte_r <= hold_byte_nxt;
    o_r         <= o_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

`ifndef SYNTHESIS
  a_ser_empty_group_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_vld && grp.n == 3'd0) |-> grp.mark)
    else $error("group without bytes carries no word mark");
  a_ser_open_byte_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_vld_r && !hold_fin_r && take) |=> (out_valid && !out_data.last_of_run))
    else $error("byte followed by another of its word flagged as last");
`endif

endmodule

// File: rtl/double_utf8_repair_filter_top.sv
`timescale 1ns / 1ps
// Channel  | Ports                          | Word
// ---------+--------------------------------+------------------------------------
// input    | in_valid, in_ready, in_data    | dur_in_t: in_byte, end_of_stream
// result   | out_valid, out_ready, out_data | dur_out_t: out_byte, last_of_run
//
// An input word is taken every cycle while every front and back decision moves at most
// one byte and out_ready stays high; a decision that moves more bytes holds its stage.
// End of stream adds flush decisions in both stages until both windows are empty.
// A result word passes the front chunk, back group, serializer hold and output registers.
// Reset (rst_n low, synchronous) empties both windows and all stage registers.
// A stalled result port fills the stage registers, then drops in_ready; nothing is lost.
module double_utf8_repair_filter_top
  import dur_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dur_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dur_out_t out_data
);

  // front stage -> back stage: bytes forwarded by one front decision
  logic   chunk_vld;
  chunk_t chunk;
  logic   chunk_done;

  // back stage -> serializer: bytes emitted by one back decision
  logic   grp_vld;
  group_t grp;
  logic   grp_done;

  // Lookahead of four, code page repair, drop of stray bytes
  dur_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .chunk_vld  (chunk_vld),
    .chunk      (chunk),
    .chunk_done (chunk_done)
  );

  // Structure check over a five byte window, one forwarded byte per cycle if grp is free
  dur_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .chunk_vld  (chunk_vld),
    .chunk      (chunk),
    .chunk_done (chunk_done),
    .grp_vld    (grp_vld),
    .grp        (grp),
    .grp_done   (grp_done)
  );

  // One result word per cycle if ready; hold the newest byte until its last flag is known
  dur_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_vld   (grp_vld),
    .grp       (grp),
    .grp_done  (grp_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_double_utf8_repair_filter_top.sv
`timescale 1ns / 1ps
module tb_double_utf8_repair_filter_top
  import dur_pkg::*;
();

  localparam int unsigned STREAM_WORDS = 460;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned SETTLE_WAIT  = 40;

  // Code points 0x80..0x9F of the single-byte code page as UTF-8.
  // A zero low byte marks a two-byte form; the rest of the page
  // (C2 A0..BF, C3 80..BF) follows by rule.
  localparam logic [0:31][23:0] CP_HIGH_SEQ = {
    24'hE282AC, 24'hC28100, 24'hE2809A, 24'hC69200,
    24'hE2809E, 24'hE280A6, 24'hE280A0, 24'hE280A1,
    24'hCB8600, 24'hE280B0, 24'hC5A000, 24'hE280B9,
    24'hC59200, 24'hC28D00, 24'hC5BD00, 24'hC28F00,
    24'hC29000, 24'hE28098, 24'hE28099, 24'hE2809C,
    24'hE2809D, 24'hE280A2, 24'hE28093, 24'hE28094,
    24'hCB9C00, 24'hE284A2, 24'hC5A100, 24'hE280BA,
    24'hC59300, 24'hC29D00, 24'hC5BE00, 24'hC5B800
  };

  // One queued input word plus the idle cycles that precede it. A set
  // drain bit makes the sender wait until every expected byte is back.
  typedef struct packed {
    dur_in_t    word;
    logic [2:0] gap;
    logic       drain;
  } send_slot_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dur_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dur_out_t out_data;

  double_utf8_repair_filter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Repair predictor: a four-byte front window that folds double-encoded
  // code page characters back to one byte, feeding a five-byte back window
  // that passes only well-formed UTF-8.
  // ---------------------------------------------------------------------
  logic [3:0][7:0] front_win  = '0;
  int unsigned     front_held = 0;
  logic [4:0][7:0] back_win   = '0;
  int unsigned     back_held  = 0;
  logic [7:0]      run_bytes [$];
  dur_out_t        repaired_q [$];

  send_slot_t  pending [$];
  logic        drain_next   = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned flushes      = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;

  // Length of the well-formed sequence at the head, or 0 for none
  function automatic int unsigned utf8_seq_len(input logic [3:0][7:0] v);
    int unsigned len;
    len = 0;
    if (!v[0][7]) begin
      len = 1;
    end else if (v[0][7:5] == 3'b110 && v[1][7:6] == 2'b10) begin
      len = 2;
    end else if (v[0][7:4] == 4'b1110 && v[1][7:6] == 2'b10 && v[2][7:6] == 2'b10) begin
      len = 3;
    end else if (v[0][7:3] == 5'b11110 && v[1][7:6] == 2'b10 && v[2][7:6] == 2'b10 &&
                 v[3][7:6] == 2'b10) begin
      len = 4;
    end
    return len;
  endfunction

  // Code page index 0..127 of a double-encoded character, or -1
  function automatic int cp1252_index(input logic [3:0][7:0] v);
    int idx;
    idx = -1;
    for (int k = 0; k < 32; k++) begin
      if (idx < 0 && v[0] == CP_HIGH_SEQ[k][23:16] && v[1] == CP_HIGH_SEQ[k][15:8] &&
          (CP_HIGH_SEQ[k][7:0] == 8'h00 || v[2] == CP_HIGH_SEQ[k][7:0]))
        idx = k;
    end
    if (idx < 0 && v[0] == 8'hC2 && v[1] >= 8'hA0 && v[1] <= 8'hBF)
      idx = int'(v[1]) - 'h80;
    else if (idx < 0 && v[0] == 8'hC3 && v[1] >= 8'h80 && v[1] <= 8'hBF)
      idx = int'(v[1]) - 'h40;
    return idx;
  endfunction

  // First four held bytes; empty positions read as zero during a flush
  function automatic logic [3:0][7:0] held_view(input logic [4:0][7:0] win,
                                                input int unsigned held);
    logic [3:0][7:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (k < held) v[k] = win[k];
    end
    return v;
  endfunction

  task automatic back_decide();
    logic [3:0][7:0] v;
    int unsigned     j;
    v = held_view(back_win, back_held);
    j = utf8_seq_len(v);
    if (j == 0) begin
      j = 1;
    end else begin
      for (int k = 0; k < j; k++) run_bytes.push_back(v[k]);
    end
    if (j > back_held) j = back_held;
    back_win  = back_win >> (8 * j);
    back_held = back_held - j;
  endtask

  task automatic back_push(input logic [7:0] b);
    if (back_held < 5) begin
      back_win[back_held] = b;
      back_held++;
    end
    if (back_held >= 5) back_decide();
  endtask

  task automatic front_decide();
    logic [3:0][7:0] v;
    int unsigned     j;
    int              idx;
    v = held_view({8'h00, front_win}, front_held);
    j = utf8_seq_len(v);
    if (j == 0) begin
      j = 1;
    end else if (j == 1) begin
      back_push(v[0]);
    end else begin
      idx = cp1252_index(v);
      if (idx >= 0) begin
        back_push(8'h80 + 8'(idx));
      end else begin
        for (int k = 0; k < j; k++) back_push(v[k]);
      end
    end
    if (j > front_held) j = front_held;
    front_win  = front_win >> (8 * j);
    front_held = front_held - j;
  endtask

  // Take one accepted word and queue the bytes it releases, marking the last
  task automatic repair_word(input dur_in_t w);
    dur_out_t r;
    run_bytes.delete();
    if (front_held < 4) begin
      front_win[front_held] = w.in_byte;
      front_held++;
    end
    if (front_held >= 4) front_decide();
    if (w.end_of_stream) begin
      while (front_held > 0) front_decide();
      while (back_held > 0) back_decide();
      front_win = '0;
      back_win  = '0;
      flushes++;
    end
    foreach (run_bytes[i]) begin
      r.out_byte    = run_bytes[i];
      r.last_of_run = (i == run_bytes.size() - 1);
      repaired_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  // Queue one byte; sender gaps come in phases: none, wide, narrow
  task automatic queue_byte(input logic [7:0] b, input logic eos);
    send_slot_t  s;
    int unsigned phase;
    phase                = (pending.size() / 60) % 3;
    s.word.in_byte       = b;
    s.word.end_of_stream = eos;
    if (phase == 0)
      s.gap = 3'd0;
    else if (phase == 1)
      s.gap = 3'($urandom_range(0, 7));
    else
      s.gap = 3'($urandom_range(0, 2));
    s.drain    = drain_next;
    drain_next = 1'b0;
    pending.push_back(s);
  endtask

  // Queue one character of doubly encoded text, or a broken or stray piece
  task automatic queue_char();
    int unsigned pick;
    int unsigned idx;
    int unsigned n;
    int unsigned conts;
    logic [23:0] seq;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      queue_byte(8'($urandom_range(0, 127)), 1'b0);
    end else if (pick < 60) begin
      idx = $urandom_range(0, 127);
      if (idx < 32) begin
        seq = CP_HIGH_SEQ[idx];
        queue_byte(seq[23:16], 1'b0);
        queue_byte(seq[15:8], 1'b0);
        if (seq[7:0] != 8'h00) queue_byte(seq[7:0], 1'b0);
      end else if (idx < 64) begin
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'(idx + 'h80), 1'b0);
      end else begin
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'(idx + 'h40), 1'b0);
      end
    end else if (pick < 90) begin
      // well-formed multi-byte sequence, or a truncated one
      n = $urandom_range(2, 4);
      case (n)
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      queue_byte(lead, 1'b0);
      conts = (pick < 80) ? n - 1 : $urandom_range(0, n - 2);
      repeat (conts) queue_byte({2'b10, 6'($urandom)}, 1'b0);
    end else begin
      queue_byte(8'($urandom), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: offer queued words, hold each until accepted
  // ---------------------------------------------------------------------
  int unsigned idle_left  = 0;
  logic        head_armed = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      idle_left  = 0;
      head_armed = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        repair_word(in_data);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!head_armed) begin
            idle_left  = pending[0].gap;
            head_armed = 1'b1;
          end
          if (idle_left > 0) begin
            // idle before the next word
            idle_left--;
            in_valid <= 1'b0;
          end else if (pending[0].drain && repaired_q.size() != 0) begin
            // pause until the block has returned everything owed
            in_valid <= 1'b0;
          end else begin
            in_valid   <= 1'b1;
            in_data    <= pending[0].word;
            head_armed = 1'b0;
            pending.pop_front();
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: check each result word against the oldest expectation
  // ---------------------------------------------------------------------
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  dur_out_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (repaired_q.size() == 0) begin
          $error("out_byte: expected none, got %h (last_of_run %b)",
                 out_data.out_byte, out_data.last_of_run);
          fail_count++;
        end else begin
          want = repaired_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   out_data.last_of_run);
            fail_count++;
          end
        end
        results_seen++;
        // stall phases: none, then a random stall after each word
        if ((results_seen / 50) % 3 == 0)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 7);
        // hold off long enough that the block fills and drops in_ready
        if (results_seen % 200 == 60) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, wait for the drain
  // ---------------------------------------------------------------------
  initial begin
    // ASCII extremes, then code page characters from the table and by rule,
    // the euro sign first; the stream ends on a repaired byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hBF, 1'b1);
    // sequences that pass unchanged: two, three and four bytes
    queue_byte(8'hD0, 1'b0);
    queue_byte(8'h90, 1'b0);
    queue_byte(8'hE4, 1'b0);
    queue_byte(8'hB8, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    // stray continuation, stray lead, then a sequence cut off by the flush
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    // a stream of one byte
    queue_byte(8'h5A, 1'b1);

    // random streams; the sender drains once right after the directed part
    // and again after each stream that ends near the midpoint
    drain_next = 1'b1;
    while (pending.size() < STREAM_WORDS) begin
      repeat ($urandom_range(3, 40)) queue_char();
      queue_byte(8'($urandom), 1'b1);
      if (pending.size() > STREAM_WORDS / 2 && pending.size() < STREAM_WORDS / 2 + 100)
        drain_next = 1'b1;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (repaired_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Sent %0d words in %0d streams; checked %0d repaired bytes.",
             words_sent, flushes, results_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
